// ----- hdl/cis_scan_pkg.sv -----
// cis_scan_pkg: shared types and constants of the cis tuple scanner
// used by cis_scan_walker and cis_tuple_io_irq_scanner_core, no dependencies

package cis_scan_pkg;

  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_END  = 2'd3;

  localparam logic [7:0] TUPLE_NULL    = 8'h00;
  localparam logic [7:0] TUPLE_CFTABLE = 8'h1B;
  localparam logic [7:0] TUPLE_END     = 8'hFF;

  localparam logic [7:0]  MIN_CFT_LEN = 8'd4;
  localparam logic [15:0] IO_MIN      = 16'h0200;
  localparam logic [15:0] IO_LIMIT    = 16'h0400;
  localparam logic [3:0]  IRQ_MIN     = 4'd3;
  localparam logic [3:0]  IRQ_MASK    = 4'hF;
  localparam logic [2:0]  CNT_MIN     = 3'd4;

  localparam logic [15:0] DEF_IO_RST  = 16'h0300;
  localparam logic [3:0]  DEF_IRQ_RST = 4'd10;

  localparam logic CFG_DEF_IO  = 1'b0;
  localparam logic CFG_DEF_IRQ = 1'b1;

  typedef struct packed {
    logic        status;
    logic [15:0] io_base;
    logic [3:0]  irq_number;
  } res_t;

endpackage

// ----- hdl/cis_tuple_io_irq_scanner_core.sv -----
// cis_tuple_io_irq_scanner_core: top level, input register, walker, result register
// depends on cis_scan_pkg and cis_scan_walker
// output: result is registered when the last byte leaves the input register
// throughput: one byte per cycle unless the output stream holds off, the walker updates once per byte
// reset: asynchronous active low, clears tuple state and loads default registers

module cis_tuple_io_irq_scanner_core import cis_scan_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] cis_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] io_base, [19:16] irq_number, [23:20] zero
  output logic        m_axis_tuser    // [0] status
);

  logic [15:0] def_io_q;
  logic [3:0]  def_irq_q;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        out_valid_q, out_valid_d;
  res_t        res_q;
  res_t        res_c;

  logic        out_free;
  logic        advance;
  logic        in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_io_q  <= DEF_IO_RST;
      def_irq_q <= DEF_IRQ_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DEF_IO) begin
        def_io_q <= cfg_wdata_i;
      end else begin
        def_irq_q <= cfg_wdata_i[3:0];
      end
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance && in_last_q) begin
      res_q <= res_c;
    end
  end

  cis_scan_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .def_io_i  (def_io_q),
    .def_irq_i (def_irq_q),
    .res_o     (res_c)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.irq_number, res_q.io_base};
  assign m_axis_tuser  = res_q.status;

endmodule

// ----- hdl/cis_scan_walker.sv -----
// cis_scan_walker: tuple walking state and per-byte update, forms the result
// depends on cis_scan_pkg

module cis_scan_walker import cis_scan_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  input  logic [15:0] def_io_i,
  input  logic [3:0]  def_irq_i,
  output res_t        res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic        cft_q, cft_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  second_q, second_d;
  logic [7:0]  latest_q, latest_d;
  logic [15:0] found_io_q, found_io_d;
  logic [3:0]  found_irq_q, found_irq_d;
  logic [2:0]  cnt_q, cnt_d;

  logic        fin;
  logic [7:0]  idx;
  logic [15:0] io_cand;
  logic [3:0]  irq_cand;
  logic [2:0]  cnt_inc;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    cft_d       = cft_q;
    len_d       = len_q;
    first_d     = first_q;
    second_d    = second_q;
    latest_d    = latest_q;
    found_io_d  = found_io_q;
    found_irq_d = found_irq_q;
    fin         = 1'b0;
    idx         = len_q - left_q;
    cnt_inc     = (cnt_q < CNT_MIN) ? cnt_q + 3'd1 : cnt_q;

    case (phase_q)
      PH_TYPE: begin
        if (!last_i && byte_i != TUPLE_NULL) begin
          if (byte_i == TUPLE_END) begin
            phase_d = PH_END;
          end else begin
            cft_d   = (byte_i == TUPLE_CFTABLE);
            phase_d = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        len_d  = byte_i;
        left_d = byte_i;
        if (byte_i == 8'd0) begin
          fin = 1'b1;
        end else begin
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (idx == 8'd0) begin
          first_d = byte_i;
        end else if (idx == 8'd1) begin
          second_d = byte_i;
        end
        latest_d = byte_i;
        left_d   = left_q - 8'd1;
        if (left_d == 8'd0) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase

    io_cand  = {second_d, first_d};
    irq_cand = latest_d[3:0] & IRQ_MASK;
    if (fin) begin
      phase_d = PH_TYPE;
      if (cft_q && len_d >= MIN_CFT_LEN) begin
        if (io_cand >= IO_MIN && io_cand < IO_LIMIT) begin
          found_io_d = io_cand;
        end
        if (irq_cand >= IRQ_MIN) begin
          found_irq_d = irq_cand;
        end
      end
    end

    cnt_d = cnt_inc;

    res_o.status = (cnt_inc < CNT_MIN);
    if (res_o.status) begin
      res_o.io_base    = 16'd0;
      res_o.irq_number = 4'd0;
    end else begin
      res_o.io_base    = (found_io_d != 16'd0) ? found_io_d : def_io_i;
      res_o.irq_number = (found_irq_d != 4'd0) ? found_irq_d : def_irq_i;
    end

    if (last_i) begin
      phase_d     = PH_TYPE;
      left_d      = 8'd0;
      cft_d       = 1'b0;
      len_d       = 8'd0;
      first_d     = 8'd0;
      second_d    = 8'd0;
      latest_d    = 8'd0;
      found_io_d  = 16'd0;
      found_irq_d = 4'd0;
      cnt_d       = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_TYPE;
      left_q      <= 8'd0;
      cft_q       <= 1'b0;
      len_q       <= 8'd0;
      first_q     <= 8'd0;
      second_q    <= 8'd0;
      latest_q    <= 8'd0;
      found_io_q  <= 16'd0;
      found_irq_q <= 4'd0;
      cnt_q       <= 3'd0;
    end else if (en_i) begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      cft_q       <= cft_d;
      len_q       <= len_d;
      first_q     <= first_d;
      second_q    <= second_d;
      latest_q    <= latest_d;
      found_io_q  <= found_io_d;
      found_irq_q <= found_irq_d;
      cnt_q       <= cnt_d;
    end
  end

  a_found_io_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_io_q == 16'd0 || (found_io_q >= IO_MIN && found_io_q < IO_LIMIT))
    else $error("found io base out of range");

  a_found_irq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_irq_q == 4'd0 || found_irq_q >= IRQ_MIN)
    else $error("found irq out of range");

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MIN)
    else $error("byte count past saturation");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != 8'd0 && left_q <= len_q)
    else $error("data phase with no bytes left");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && last_i |=> phase_q == PH_TYPE && cnt_q == 3'd0 && found_io_q == 16'd0)
    else $error("state not cleared after last byte");

endmodule

// ----- dv/tb.sv -----
// tb: self-checking bench for cis_tuple_io_irq_scanner_core
// streams cis buffers in, predicts each io/irq report and checks it on the output stream
// depends on cis_scan_pkg and the core rtl

module tb;
  import cis_scan_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [15:0] cfg_wdata_i   = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] cis_byte
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // [15:0] io_base, [19:16] irq_number, [23:20] zero
  logic        m_axis_tuser;           // [0] status

  cis_tuple_io_irq_scanner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // walker copy
  logic [1:0]  walk_phase  = PH_TYPE;
  logic [7:0]  walk_left   = 8'h00;
  logic [7:0]  walk_len    = 8'h00;
  logic        walk_cft    = 1'b0;
  logic [7:0]  data_first  = 8'h00;
  logic [7:0]  data_second = 8'h00;
  logic [7:0]  data_latest = 8'h00;
  logic [15:0] hit_io      = 16'h0000;
  logic [3:0]  hit_irq     = 4'h0;
  logic [2:0]  seen_cnt    = 3'd0;
  logic [15:0] dflt_io     = DEF_IO_RST;
  logic [3:0]  dflt_irq    = DEF_IRQ_RST;

  res_t        io_irq_reports[$];
  logic [7:0]  cis_buf[$];
  int          mismatches    = 0;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          rx_hold_req   = 0;
  int          rx_hold_left  = 0;

  function automatic void clear_walk();
    walk_phase  = PH_TYPE;
    walk_left   = 8'h00;
    walk_len    = 8'h00;
    walk_cft    = 1'b0;
    data_first  = 8'h00;
    data_second = 8'h00;
    data_latest = 8'h00;
    hit_io      = 16'h0000;
    hit_irq     = 4'h0;
    seen_cnt    = 3'd0;
  endfunction

  function automatic void close_tuple();
    logic [15:0] io;
    logic [3:0]  q;
    if (walk_cft && walk_len >= MIN_CFT_LEN) begin
      io = {data_second, data_first};
      q  = data_latest[3:0] & IRQ_MASK;
      if (io >= IO_MIN && io < IO_LIMIT) hit_io = io;
      if (q >= IRQ_MIN) hit_irq = q;
    end
    walk_phase = PH_TYPE;
  endfunction

  function automatic void walk_cis_byte(input logic [7:0] b, input logic lst);
    logic [7:0] idx;
    res_t       rep;
    if (seen_cnt < CNT_MIN) seen_cnt = seen_cnt + 3'd1;
    case (walk_phase)
      PH_TYPE: begin
        if (!lst && b != TUPLE_NULL) begin
          if (b == TUPLE_END) begin
            walk_phase = PH_END;
          end else begin
            walk_cft   = (b == TUPLE_CFTABLE);
            walk_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        walk_len  = b;
        walk_left = b;
        if (b == 8'h00) close_tuple();
        else walk_phase = PH_DATA;
      end
      PH_DATA: begin
        idx = walk_len - walk_left;
        if (idx == 8'd0) data_first = b;
        else if (idx == 8'd1) data_second = b;
        data_latest = b;
        walk_left   = walk_left - 8'd1;
        if (walk_left == 8'h00) close_tuple();
      end
      default: ;
    endcase
    if (lst) begin
      if (seen_cnt < CNT_MIN) begin
        rep.status     = 1'b1;
        rep.io_base    = 16'h0000;
        rep.irq_number = 4'h0;
      end else begin
        rep.status     = 1'b0;
        rep.io_base    = (hit_io != 16'h0000) ? hit_io : dflt_io;
        rep.irq_number = (hit_irq != 4'h0) ? hit_irq : dflt_irq;
      end
      io_irq_reports.push_back(rep);
      clear_walk();
    end
  endfunction

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEF_IO) dflt_io = val;
    else dflt_irq = val[3:0];
    @(posedge clk_i);
  endtask

  // leaves tvalid high after the transaction so bursts run back to back
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if ($urandom_range(99) < in_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    walk_cis_byte(b, lst);
  endtask

  task automatic send_buffer();
    for (int i = 0; i < cis_buf.size(); i++) send_byte(cis_buf[i], i == cis_buf.size() - 1);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (io_irq_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic build_buffer();
    int          kind;
    int          ntup;
    int          r;
    int          len;
    int          cut;
    logic [15:0] io;
    logic [7:0]  t;
    cis_buf.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) cis_buf.push_back(8'($urandom));
    end else if (kind < 18) begin
      repeat ($urandom_range(4, 20)) cis_buf.push_back(8'($urandom));
    end else begin
      ntup = $urandom_range(1, 4);
      repeat (ntup) begin
        r = $urandom_range(99);
        if (r < 12) begin
          cis_buf.push_back(TUPLE_NULL);
        end else if (r < 72) begin
          r = $urandom_range(99);
          if (r < 75) len = $urandom_range(4, 6);
          else if (r < 90) len = $urandom_range(0, 3);
          else len = $urandom_range(7, 12);
          if ($urandom_range(1)) io = 16'($urandom_range(16'h01F8, 16'h0408));
          else io = 16'($urandom);
          cis_buf.push_back(TUPLE_CFTABLE);
          cis_buf.push_back(len[7:0]);
          for (int i = 0; i < len; i++) begin
            if (i == 0) cis_buf.push_back(io[7:0]);
            else if (i == 1) cis_buf.push_back(io[15:8]);
            else cis_buf.push_back(8'($urandom));
          end
        end else begin
          t = 8'($urandom_range(1, 254));
          if (t == TUPLE_CFTABLE) t = t + 8'd1;
          len = $urandom_range(0, 3);
          cis_buf.push_back(t);
          cis_buf.push_back(len[7:0]);
          repeat (len) cis_buf.push_back(8'($urandom));
        end
      end
      if ($urandom_range(99) < 15) begin
        cis_buf.push_back(TUPLE_END);
        repeat ($urandom_range(0, 3)) cis_buf.push_back(8'($urandom));
      end
      if ($urandom_range(99) < 20 && cis_buf.size() > 1) begin
        cut = $urandom_range(1, cis_buf.size() - 1);
        while (cis_buf.size() > cut) void'(cis_buf.pop_back());
      end
    end
  endtask

  // receiver: random stalls plus long hold-offs on request
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left  = rx_hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk_i) begin : report_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (io_irq_reports.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected report status=%0d io_base=%h irq=%0d", $time,
                 m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[19:16]);
      end else begin
        want = io_irq_reports.pop_front();
        if (m_axis_tuser !== want.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_axis_tuser);
        end
        if (m_axis_tdata[15:0] !== want.io_base) begin
          mismatches++;
          $display("%0t: io_base expected %h actual %h", $time, want.io_base,
                   m_axis_tdata[15:0]);
        end
        if (m_axis_tdata[19:16] !== want.irq_number) begin
          mismatches++;
          $display("%0t: irq_number expected %0d actual %0d", $time, want.irq_number,
                   m_axis_tdata[19:16]);
        end
      end
    end
  end

  task automatic test_short_buffers();
    cis_buf = '{8'h1B};
    send_buffer();
    cis_buf = '{8'h00, 8'hFF, 8'h00};
    send_buffer();
    settle();
  endtask

  // null tuple, zero length tuple, type byte flagged last
  task automatic test_null_and_empty();
    cis_buf = '{8'h00, 8'h1B, 8'h00, 8'h1B};
    send_buffer();
    settle();
  endtask

  task automatic test_cftable_hits();
    cis_buf = '{8'h1B, 8'h05, 8'h00, 8'h02, 8'hAA, 8'hBB, 8'h23};
    send_buffer();
    cis_buf = '{8'h1B, 8'h04, 8'hFF, 8'h03, 8'h00, 8'hF2,
                8'h1B, 8'h04, 8'h00, 8'h04, 8'h00, 8'h0F, 8'hFF, 8'h55};
    send_buffer();
    settle();
  endtask

  task automatic test_cut_off();
    cis_buf = '{8'h1B, 8'h04, 8'h40, 8'h02, 8'h05};
    send_buffer();
    settle();
  endtask

  task automatic test_backpressure();
    in_idle_pct   = 0;
    out_stall_pct = 0;
    rx_hold_req   = 400;
    repeat (30) begin
      cis_buf.delete();
      repeat (4) cis_buf.push_back(8'($urandom));
      send_buffer();
    end
    settle();
    build_buffer();
    send_buffer();
    settle();
  endtask

  task automatic test_random(input logic [15:0] io_dflt, input logic [3:0] irq_dflt,
                             input int in_pct, input int out_pct, input int n_bytes);
    int sent;
    sent = 0;
    write_reg(CFG_DEF_IO, io_dflt);
    write_reg(CFG_DEF_IRQ, {12'h000, irq_dflt});
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    while (sent < n_bytes) begin
      build_buffer();
      send_buffer();
      sent += cis_buf.size();
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_short_buffers();
    test_null_and_empty();
    test_cftable_hits();
    test_cut_off();
    test_random(16'h0000, 4'd1, 0, 0, 450);
    test_random(16'hFFFF, 4'd15, 76, 0, 450);
    test_random(16'($urandom), 4'd0, 0, 76, 450);
    test_random(16'($urandom), 4'($urandom_range(1, 15)), 18, 18, 450);
    test_backpressure();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
